// File: design/bsd_pkg.sv
// shared types and constants of the bmp stream pixel decoder
package bsd_pkg;

  localparam int MAX_DIM   = 4096;
  localparam int DIM_W     = $clog2(MAX_DIM + 1);
  localparam int COORD_W   = 12;

  // byte positions at which header fields complete
  localparam logic [31:0] N_SIG      = 32'd1;
  localparam logic [31:0] N_OFFSET   = 32'd13;
  localparam logic [31:0] N_WIDTH    = 32'd21;
  localparam logic [31:0] N_HEIGHT   = 32'd25;
  localparam logic [31:0] N_DEPTH    = 32'd29;
  localparam logic [31:0] N_COMP     = 32'd33;
  localparam logic [31:0] N_HDR_END  = 32'd53;
  localparam logic [31:0] N_MASK_R   = 32'd57;
  localparam logic [31:0] N_MASK_G   = 32'd61;
  localparam logic [31:0] N_MASK_B   = 32'd65;
  localparam logic [31:0] N_SHIFT_R  = 32'd58;
  localparam logic [31:0] N_SHIFT_G  = 32'd62;
  localparam logic [31:0] N_SHIFT_B  = 32'd66;
  localparam logic [31:0] N_SHIFT_A  = 32'd67;
  localparam logic [31:0] HDR_LEN    = 32'd54;
  localparam logic [31:0] HDR_LEN_BF = 32'd66;

  localparam logic [15:0] SIG_BM     = 16'h4D42;
  localparam logic [31:0] COMP_RGB   = 32'd0;
  localparam logic [31:0] COMP_BF    = 32'd3;
  localparam logic [15:0] DEPTH_24   = 16'd24;
  localparam logic [15:0] DEPTH_32   = 16'd32;

  localparam logic [31:0] MASK_R_DEF = 32'h00FF0000;
  localparam logic [31:0] MASK_G_DEF = 32'h0000FF00;
  localparam logic [31:0] MASK_B_DEF = 32'h000000FF;
  localparam logic [31:0] MASK_A_DEF = 32'hFF000000;

  localparam int          FIFO_DEPTH = 4;
  localparam int          PTR_W      = $clog2(FIFO_DEPTH);
  localparam int          CNT_W      = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SIG      = 3'd1,
    ST_DIM      = 3'd2,
    ST_COMP     = 3'd3,
    ST_DEPTH    = 3'd4,
    ST_BF_DEPTH = 3'd5,
    ST_TRUNC    = 3'd6,
    ST_OFFSET   = 3'd7
  } status_t;

  typedef enum logic {
    KIND_PIXEL  = 1'b0,
    KIND_STATUS = 1'b1
  } kind_t;

  typedef struct packed {
    logic bitfields;
    logic bpp32;
    logic topdown;
    logic hdr_done;
  } flags_t;

  typedef struct packed {
    kind_t                kind;
    logic [COORD_W-1:0]   pixel_x;
    logic [COORD_W-1:0]   pixel_y;
    logic [7:0]           red;
    logic [7:0]           green;
    logic [7:0]           blue;
    logic [7:0]           alpha;
    status_t              status;
    logic                 last;
  } out_item_t;

  // up to two result items from one byte, first in item0
  typedef struct packed {
    logic [1:0] cnt;
    out_item_t  item0;
    out_item_t  item1;
  } push_t;

  // index of the lowest set bit, 0 for an empty mask
  function automatic logic [4:0] low_bit(input logic [31:0] m);
    logic [31:0] oh;
    logic [4:0]  idx;
    oh  = m & (~m + 32'd1);
    idx = '0;
    for (int k = 0; k < 5; k++) begin
      for (int i = 0; i < 32; i++) begin
        if (((i >> k) & 1) == 1) idx[k] = idx[k] | oh[i];
      end
    end
    return idx;
  endfunction

endpackage

// File: design/bsd_if.sv
// valid/ready stream interfaces for file bytes and decoded items
interface bsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, data_byte, final_byte, input ready);
  modport sink   (input valid, data_byte, final_byte, output ready);
endinterface

interface bsd_out_if import bsd_pkg::*; ();
  logic               valid;
  logic               ready;
  kind_t              kind;
  logic [COORD_W-1:0] pixel_x;
  logic [COORD_W-1:0] pixel_y;
  logic [7:0]         red;
  logic [7:0]         green;
  logic [7:0]         blue;
  logic [7:0]         alpha;
  status_t            status;
  logic               last;

  modport source (output valid, kind, pixel_x, pixel_y, red, green, blue, alpha, status, last,
                  input ready);
  modport sink   (input valid, kind, pixel_x, pixel_y, red, green, blue, alpha, status, last,
                  output ready);
endinterface

// File: design/bsd_decode.sv
// input register, header capture and checks, pixel assembly
module bsd_decode import bsd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  bsd_in_if.sink      in_chan,
  input  logic        room,
  output push_t       push
);

  logic              vld_r, vld_nxt;
  logic [7:0]        byte_r;
  logic              fin_r;
  logic              fire;

  logic [31:0]       count_r, count_nxt;
  logic [31:0]       hdr_r, hdr_nxt;
  logic [31:0]       off_r, off_nxt;
  logic [DIM_W-1:0]  width_r, width_nxt;
  logic [DIM_W-1:0]  height_r, height_nxt;
  flags_t            flags_r, flags_nxt;
  logic              d24_r, d24_nxt;
  logic              d32_r, d32_nxt;
  logic [31:0]       mask_r [4];
  logic [31:0]       mask_nxt [4];
  logic [4:0]        shift_r [4];
  logic [4:0]        shift_nxt [4];
  logic [23:0]       asm_r, asm_nxt;
  logic [1:0]        pbyte_r, pbyte_nxt;
  logic [1:0]        pad_r, pad_nxt;
  logic [DIM_W-1:0]  col_r, col_nxt;
  logic [DIM_W-1:0]  row_r, row_nxt;
  status_t           err_r, err_nxt;
  logic              done_r, done_nxt;

  logic [31:0]       mag;
  logic [31:0]       px;
  logic              in_pixels;
  logic              end_row;
  logic              pix_out;
  logic [DIM_W-1:0]  y_flip;
  logic [DIM_W-1:0]  col_inc;
  logic [DIM_W-1:0]  row_inc;
  logic [31:0]       shift_src;
  logic              shift_en;
  logic [1:0]        shift_sel;
  out_item_t         pix_item, st_item;

  assign fire          = vld_r & room;
  assign in_chan.ready = ~vld_r | room;

  always_comb begin
    vld_nxt = vld_r;
    if (in_chan.valid && in_chan.ready) vld_nxt = 1'b1;
    else if (fire)                      vld_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    if (in_chan.valid && in_chan.ready) begin
      byte_r <= in_chan.data_byte;
      fin_r  <= in_chan.final_byte;
    end
  end

  assign px      = {8'd0, asm_r} | ({24'd0, byte_r} << {pbyte_r, 3'b000});
  assign col_inc = col_r + DIM_W'(1);
  assign row_inc = row_r + DIM_W'(1);
  assign y_flip  = height_r - DIM_W'(1) - row_r;
  assign mag     = hdr_nxt[31] ? (~hdr_nxt + 32'd1) : hdr_nxt;

  always_comb begin
    shift_en  = 1'b0;
    shift_sel = 2'd0;
    if (count_r == N_SHIFT_R) begin
      shift_en = 1'b1; shift_sel = 2'd0;
    end else if (count_r == N_SHIFT_G) begin
      shift_en = 1'b1; shift_sel = 2'd1;
    end else if (count_r == N_SHIFT_B) begin
      shift_en = 1'b1; shift_sel = 2'd2;
    end else if (count_r == N_SHIFT_A) begin
      shift_en = 1'b1; shift_sel = 2'd3;
    end
    shift_src = mask_r[shift_sel];
  end

  always_comb begin
    hdr_nxt    = {byte_r, hdr_r[31:8]};
    count_nxt  = (count_r == 32'hFFFF_FFFF) ? count_r : count_r + 32'd1;
    off_nxt    = off_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    flags_nxt  = flags_r;
    d24_nxt    = d24_r;
    d32_nxt    = d32_r;
    mask_nxt   = mask_r;
    shift_nxt  = shift_r;
    asm_nxt    = asm_r;
    pbyte_nxt  = pbyte_r;
    pad_nxt    = pad_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    err_nxt    = err_r;
    done_nxt   = done_r;
    end_row    = 1'b0;
    pix_out    = 1'b0;

    if (count_r == N_SIG && hdr_nxt[31:16] != SIG_BM) begin
      if (err_nxt == ST_OK) err_nxt = ST_SIG;
    end
    if (count_r == N_OFFSET) off_nxt = hdr_nxt;
    if (count_r == N_WIDTH) begin
      if (hdr_nxt >= 32'd1 && hdr_nxt <= 32'(MAX_DIM)) width_nxt = hdr_nxt[DIM_W-1:0];
      else if (err_nxt == ST_OK) err_nxt = ST_DIM;
    end
    if (count_r == N_HEIGHT) begin
      if (hdr_nxt[31]) flags_nxt.topdown = 1'b1;
      if (mag >= 32'd1 && mag <= 32'(MAX_DIM)) height_nxt = mag[DIM_W-1:0];
      else if (err_nxt == ST_OK) err_nxt = ST_DIM;
    end
    if (count_r == N_DEPTH) begin
      d24_nxt = (hdr_nxt[31:16] == DEPTH_24);
      d32_nxt = (hdr_nxt[31:16] == DEPTH_32);
    end
    if (count_r == N_COMP) begin
      if (hdr_nxt == COMP_BF) flags_nxt.bitfields = 1'b1;
      else if (hdr_nxt != COMP_RGB && err_nxt == ST_OK) err_nxt = ST_COMP;
      if (!d24_r && !d32_r && err_nxt == ST_OK) err_nxt = ST_DEPTH;
      if (flags_nxt.bitfields && !d32_r && err_nxt == ST_OK) err_nxt = ST_BF_DEPTH;
      if (d32_r) flags_nxt.bpp32 = 1'b1;
    end
    if (count_r == N_HDR_END) begin
      if (off_r < (flags_r.bitfields ? HDR_LEN_BF : HDR_LEN) && err_nxt == ST_OK)
        err_nxt = ST_OFFSET;
      flags_nxt.hdr_done = 1'b1;
    end
    if (flags_r.bitfields) begin
      if (count_r == N_MASK_R) mask_nxt[0] = hdr_nxt;
      if (count_r == N_MASK_G) mask_nxt[1] = hdr_nxt;
      if (count_r == N_MASK_B) begin
        mask_nxt[2] = hdr_nxt;
        mask_nxt[3] = ~(mask_r[0] | mask_r[1] | hdr_nxt);
      end
      // shifts follow the masks a byte or two later, before any pixel can complete
      if (shift_en) shift_nxt[shift_sel] = low_bit(shift_src);
    end

    in_pixels = flags_r.hdr_done && err_r == ST_OK && !done_r &&
                count_r >= off_r && count_r > N_HDR_END;
    if (in_pixels) begin
      if (pad_r != 2'd0) begin
        pad_nxt = pad_r - 2'd1;
        if (pad_r == 2'd1) end_row = 1'b1;
      end else if (pbyte_r == (flags_r.bpp32 ? 2'd3 : 2'd2)) begin
        pix_out   = 1'b1;
        asm_nxt   = '0;
        pbyte_nxt = 2'd0;
        col_nxt   = col_inc;
        if (col_inc >= width_r) begin
          // 24 bpp rows pad to a word boundary: the pad is width mod 4
          if (flags_r.bpp32 || width_r[1:0] == 2'd0) end_row = 1'b1;
          else pad_nxt = width_r[1:0];
        end
      end else begin
        asm_nxt   = px[23:0];
        pbyte_nxt = pbyte_r + 2'd1;
      end
    end
    if (end_row) begin
      col_nxt = '0;
      row_nxt = row_inc;
      if (row_inc >= height_r) done_nxt = 1'b1;
    end
  end

  always_comb begin
    pix_item         = '0;
    pix_item.kind    = KIND_PIXEL;
    pix_item.pixel_x = col_r[COORD_W-1:0];
    pix_item.pixel_y = flags_r.topdown ? row_r[COORD_W-1:0] : y_flip[COORD_W-1:0];
    pix_item.status  = ST_OK;
    if (flags_r.bitfields) begin
      pix_item.red   = 8'((px & mask_r[0]) >> shift_r[0]);
      pix_item.green = 8'((px & mask_r[1]) >> shift_r[1]);
      pix_item.blue  = 8'((px & mask_r[2]) >> shift_r[2]);
      pix_item.alpha = (mask_r[3] != 32'd0) ? 8'((px & mask_r[3]) >> shift_r[3]) : 8'hFF;
    end else begin
      pix_item.red   = px[23:16];
      pix_item.green = px[15:8];
      pix_item.blue  = px[7:0];
      pix_item.alpha = flags_r.bpp32 ? px[31:24] : 8'hFF;
    end

    st_item      = '0;
    st_item.kind = KIND_STATUS;
    st_item.last = 1'b1;
    if (!flags_nxt.hdr_done)  st_item.status = ST_TRUNC;
    else if (err_nxt != ST_OK) st_item.status = err_nxt;
    else if (!done_nxt)       st_item.status = ST_TRUNC;
    else                      st_item.status = ST_OK;
  end

  always_comb begin
    push       = '0;
    push.item1 = st_item;
    if (fire) begin
      push.cnt   = {1'b0, pix_out} + {1'b0, fin_r};
      push.item0 = pix_out ? pix_item : st_item;
    end else begin
      push.item0 = pix_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (fire && fin_r)) begin
      count_r   <= '0;
      hdr_r     <= '0;
      off_r     <= '0;
      width_r   <= '0;
      height_r  <= '0;
      flags_r   <= '0;
      d24_r     <= 1'b0;
      d32_r     <= 1'b0;
      mask_r[0] <= MASK_R_DEF;
      mask_r[1] <= MASK_G_DEF;
      mask_r[2] <= MASK_B_DEF;
      mask_r[3] <= MASK_A_DEF;
      for (int i = 0; i < 4; i++) shift_r[i] <= '0;
      asm_r     <= '0;
      pbyte_r   <= '0;
      pad_r     <= '0;
      col_r     <= '0;
      row_r     <= '0;
      err_r     <= ST_OK;
      done_r    <= 1'b0;
    end else if (fire) begin
      count_r  <= count_nxt;
      hdr_r    <= hdr_nxt;
      off_r    <= off_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      flags_r  <= flags_nxt;
      d24_r    <= d24_nxt;
      d32_r    <= d32_nxt;
      mask_r   <= mask_nxt;
      shift_r  <= shift_nxt;
      asm_r    <= asm_nxt;
      pbyte_r  <= pbyte_nxt;
      pad_r    <= pad_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      err_r    <= err_nxt;
      done_r   <= done_nxt;
    end
  end

endmodule

// File: design/bsd_out_fifo.sv
// four-entry result queue taking up to two items per cycle
module bsd_out_fifo import bsd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  push_t      push,
  output logic       room,
  bsd_out_if.source  out_chan
);

  out_item_t         mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              pop;
  logic [PTR_W-1:0]  wr_ptr_p1;
  out_item_t         head;

  assign room      = (cnt_r <= CNT_W'(FIFO_DEPTH - 2));
  assign pop       = out_chan.valid & out_chan.ready;
  assign wr_ptr_p1 = wr_ptr_r + PTR_W'(1);

  assign wr_ptr_nxt = wr_ptr_r + PTR_W'(push.cnt);
  assign rd_ptr_nxt = rd_ptr_r + PTR_W'(pop);
  assign cnt_nxt    = cnt_r + CNT_W'(push.cnt) - CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (push.cnt != 2'd0) mem_r[wr_ptr_r]  <= push.item0;
    if (push.cnt == 2'd2) mem_r[wr_ptr_p1] <= push.item1;
  end

  assign head             = mem_r[rd_ptr_r];
  assign out_chan.valid   = (cnt_r != '0);
  assign out_chan.kind    = head.kind;
  assign out_chan.pixel_x = head.pixel_x;
  assign out_chan.pixel_y = head.pixel_y;
  assign out_chan.red     = head.red;
  assign out_chan.green   = head.green;
  assign out_chan.blue    = head.blue;
  assign out_chan.alpha   = head.alpha;
  assign out_chan.status  = head.status;
  assign out_chan.last    = head.last;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(FIFO_DEPTH))
    else $error("result queue over-full");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push.cnt != 2'd0) |-> room)
    else $error("push into queue without room");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != CNT_W'(FIFO_DEPTH)) |-> (PTR_W'(wr_ptr_r - rd_ptr_r) == PTR_W'(cnt_r)))
    else $error("queue pointers disagree with fill count");

endmodule

// File: design/bmp_stream_pixel_decoder_core.sv
// path: a byte transfer is captured in the input register, decoded from there once the result
// queue has room and written to the queue, from which its results are offered on the output
// throughput: one byte per cycle, set by the input register and the four-entry result
// queue, which takes the pixel and status items a final byte can raise in one cycle;
// input stalls only while the queue holds three or more items
// reset: synchronous, clears all header and pixel state and the queue pointers and fill count
// at once; the header and pixel state also returns to reset after each status item
module bmp_stream_pixel_decoder_core import bsd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  bsd_in_if.sink    in_chan,
  bsd_out_if.source out_chan
);

  push_t push;
  logic  room;

  bsd_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .room    (room),
    .push    (push)
  );

  bsd_out_fifo u_out_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .room     (room),
    .out_chan (out_chan)
  );

endmodule
